### rtl/assert_macros.svh
// Assertion macros shared by the ALU RTL.
// No dependencies; the SYNTH define removes every assertion body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/lralu_pkg.sv
// Package for the ALU: field types, flag layout, operation codes, constants.
// No dependencies.
`default_nettype none
package lralu_pkg;

  typedef logic [5:0]  mode_t;
  typedef logic [15:0] word_t;
  typedef logic [7:0]  byte_t;
  typedef logic [2:0]  bit_idx_t;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  localparam mode_t MODE_ADD   = 6'd0;
  localparam mode_t MODE_ADC   = 6'd1;
  localparam mode_t MODE_SUB   = 6'd2;
  localparam mode_t MODE_SBC   = 6'd3;
  localparam mode_t MODE_AND   = 6'd4;
  localparam mode_t MODE_OR    = 6'd5;
  localparam mode_t MODE_XOR   = 6'd6;
  localparam mode_t MODE_CP    = 6'd7;
  localparam mode_t MODE_INC   = 6'd8;
  localparam mode_t MODE_DEC   = 6'd9;
  localparam mode_t MODE_SWAP  = 6'd10;
  localparam mode_t MODE_DAA   = 6'd11;
  localparam mode_t MODE_CPL   = 6'd12;
  localparam mode_t MODE_CCF   = 6'd13;
  localparam mode_t MODE_SCF   = 6'd14;
  localparam mode_t MODE_RLCA  = 6'd15;
  localparam mode_t MODE_RLA   = 6'd16;
  localparam mode_t MODE_RRCA  = 6'd17;
  localparam mode_t MODE_RRA   = 6'd18;
  localparam mode_t MODE_RLC   = 6'd19;
  localparam mode_t MODE_RL    = 6'd20;
  localparam mode_t MODE_RRC   = 6'd21;
  localparam mode_t MODE_RR    = 6'd22;
  localparam mode_t MODE_SLA   = 6'd23;
  localparam mode_t MODE_SRA   = 6'd24;
  localparam mode_t MODE_SRL   = 6'd25;
  localparam mode_t MODE_BIT   = 6'd26;
  localparam mode_t MODE_SET   = 6'd27;
  localparam mode_t MODE_RES   = 6'd28;
  localparam mode_t MODE_ADD16 = 6'd29;
  localparam mode_t MODE_ADDSP = 6'd30;
  localparam mode_t MODE_INC16 = 6'd31;
  localparam mode_t MODE_DEC16 = 6'd32;

  localparam byte_t DAA_BCD_MAX     = 8'h99;
  localparam byte_t DAA_ADJ_HI      = 8'h60;
  localparam byte_t DAA_ADJ_LO      = 8'h06;
  localparam byte_t DAA_SUB_HI      = 8'hA0;
  localparam byte_t DAA_SUB_LO      = 8'h0A;
  localparam byte_t DAA_SUB_LO_CY   = 8'h90;
  localparam byte_t DAA_SUB_LO_NCY  = 8'hF0;
  localparam logic [3:0] NIBBLE_MAX = 4'h9;

endpackage
`default_nettype wire

### rtl/lralu_if.sv
// Handshake channels of the ALU: request (operation and operands) and response.
// Depends on lralu_pkg.
`default_nettype none
interface lralu_req_if;
  import lralu_pkg::*;

  logic     valid;
  logic     ready;
  mode_t    mode;
  word_t    operand_a;
  word_t    operand_b;
  bit_idx_t bit_index;

  modport source (output valid, output mode, output operand_a, output operand_b,
                  output bit_index, input ready);
  modport sink (input valid, input mode, input operand_a, input operand_b,
                input bit_index, output ready);
endinterface

interface lralu_rsp_if;
  import lralu_pkg::*;

  logic       valid;
  logic       ready;
  word_t      result;
  logic [3:0] flags_out;

  modport source (output valid, output result, output flags_out, input ready);
  modport sink (input valid, input result, input flags_out, output ready);
endinterface
`default_nettype wire

### rtl/cpu_alu_with_flags_core.sv
// 8/16-bit ALU with a Z/N/H/C flag register, top level.
// Depends on lralu_pkg, lralu_if.sv and assert_macros.svh.
//
// Usage: operations enter on the req channel (mode, operand_a, operand_b,
// bit_index) and each one produces exactly one transfer on the rsp channel
// (result, flags_out). A transfer happens when valid and ready are both high.
// The result is registered in the output register, or in the skid register when
// the receiver stalls. The flag register is updated at the request transfer, so
// the next operation sees the new flags in the very next cycle, and one operation
// per cycle is sustained while rsp.ready stays high. The whole operation is one
// combinational pass through the adders and the flag logic between the request
// and the result register.
// When the receiver stalls, one more operation is held in a skid register;
// req.ready then drops until the output register drains. req.ready comes from
// a register and does not depend on rsp.ready.
// Reset (rst, synchronous) clears the flags and empties both registers.
`default_nettype none
`include "assert_macros.svh"
module cpu_alu_with_flags_core (
  input  logic          clk,
  input  logic          rst,
  lralu_req_if.sink     req,
  lralu_rsp_if.source   rsp
);
  import lralu_pkg::*;

  flags_t flags;
  flags_t flags_next;
  word_t  res_next;

  logic   out_valid;
  word_t  out_result;
  flags_t out_flags;
  logic   skid_valid;
  word_t  skid_result;
  flags_t skid_flags;

  logic   accept;
  logic   out_free;

  byte_t      a;
  byte_t      b;
  byte_t      r8;
  byte_t      daa_adj;
  byte_t      bit_mask;
  logic       cin;
  logic [8:0] sum9;
  logic [8:0] diff9;
  logic [4:0] hsum;
  logic [4:0] hdiff;
  logic [16:0] sum17;
  logic [12:0] sum13;

  assign a = req.operand_a[7:0];
  assign b = req.operand_b[7:0];
  assign bit_mask = 8'd1 << req.bit_index;

  always_comb begin
    cin = 1'b0;
    if (req.mode == MODE_ADC || req.mode == MODE_SBC) begin
      cin = flags.c;
    end
    sum9  = {1'b0, a} + {1'b0, b} + {8'd0, cin};
    diff9 = {1'b0, a} - {1'b0, b} - {8'd0, cin};
    hsum  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
    hdiff = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
    sum17 = {1'b0, req.operand_a} + {1'b0, req.operand_b};
    sum13 = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
  end

  always_comb begin
    daa_adj = 8'd0;
    if (!flags.n) begin
      if (a > DAA_BCD_MAX || flags.c) begin
        daa_adj = daa_adj | DAA_ADJ_HI;
      end
      if (a[3:0] > NIBBLE_MAX || flags.h) begin
        daa_adj = daa_adj | DAA_ADJ_LO;
      end
    end else begin
      if (flags.c && !flags.h) begin
        daa_adj = DAA_SUB_HI;
      end
      if (flags.h) begin
        daa_adj = DAA_SUB_LO | (flags.c ? DAA_SUB_LO_CY : DAA_SUB_LO_NCY);
      end
    end
  end

  always_comb begin
    r8 = 8'd0;
    res_next = 16'd0;
    flags_next = flags;
    case (req.mode)
      MODE_ADD, MODE_ADC: begin
        r8 = sum9[7:0];
        flags_next = '{z: (r8 == 8'd0), n: 1'b0, h: hsum[4], c: sum9[8]};
      end
      MODE_SUB, MODE_SBC, MODE_CP: begin
        r8 = (req.mode == MODE_CP) ? a : diff9[7:0];
        flags_next = '{z: (diff9[7:0] == 8'd0), n: 1'b1, h: hdiff[4], c: diff9[8]};
      end
      MODE_AND: begin
        r8 = a & b;
        flags_next = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      MODE_OR: begin
        r8 = a | b;
        flags_next = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      MODE_XOR: begin
        r8 = a ^ b;
        flags_next = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      MODE_INC: begin
        r8 = a + 8'd1;
        flags_next = '{z: (r8 == 8'd0), n: 1'b0, h: (a[3:0] == 4'hF), c: flags.c};
      end
      MODE_DEC: begin
        r8 = a - 8'd1;
        flags_next = '{z: (r8 == 8'd0), n: 1'b1, h: (a[3:0] == 4'h0), c: flags.c};
      end
      MODE_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        flags_next = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      MODE_DAA: begin
        r8 = a + daa_adj;
        flags_next = '{z: (r8 == 8'd0), n: flags.n, h: 1'b0,
                       c: flags.c | (!flags.n && (a > DAA_BCD_MAX))};
      end
      MODE_CPL: begin
        r8 = ~a;
        flags_next = '{z: flags.z, n: 1'b1, h: 1'b1, c: flags.c};
      end
      MODE_CCF: begin
        r8 = a;
        flags_next = '{z: flags.z, n: 1'b0, h: 1'b0, c: !flags.c};
      end
      MODE_SCF: begin
        r8 = a;
        flags_next = '{z: flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      MODE_RLCA: begin
        r8 = {a[6:0], a[7]};
        flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
      end
      MODE_RLA: begin
        r8 = {a[6:0], flags.c};
        flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
      end
      MODE_RRCA: begin
        r8 = {a[0], a[7:1]};
        flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
      end
      MODE_RRA: begin
        r8 = {flags.c, a[7:1]};
        flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
      end
      MODE_RLC: begin
        r8 = {a[6:0], a[7]};
        flags_next = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
      end
      MODE_RL: begin
        r8 = {a[6:0], flags.c};
        flags_next = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
      end
      MODE_RRC: begin
        r8 = {a[0], a[7:1]};
        flags_next = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      MODE_RR: begin
        r8 = {flags.c, a[7:1]};
        flags_next = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      MODE_SLA: begin
        r8 = {a[6:0], 1'b0};
        flags_next = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
      end
      MODE_SRA: begin
        r8 = {a[7], a[7:1]};
        flags_next = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      MODE_SRL: begin
        r8 = {1'b0, a[7:1]};
        flags_next = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      MODE_BIT: begin
        r8 = a;
        flags_next = '{z: !a[req.bit_index], n: 1'b0, h: 1'b1, c: flags.c};
      end
      MODE_SET: begin
        r8 = a | bit_mask;
      end
      MODE_RES: begin
        r8 = a & ~bit_mask;
      end
      default: begin
        r8 = 8'd0;
      end
    endcase

    res_next = {8'd0, r8};
    case (req.mode)
      MODE_ADD16: begin
        res_next = sum17[15:0];
        flags_next = '{z: flags.z, n: 1'b0, h: sum13[12], c: sum17[16]};
      end
      MODE_ADDSP: begin
        res_next = req.operand_a + {{8{b[7]}}, b};
        flags_next = '{z: 1'b0, n: 1'b0, h: hsum[4], c: sum9[8]};
      end
      MODE_INC16: begin
        res_next = req.operand_a + 16'd1;
      end
      MODE_DEC16: begin
        res_next = req.operand_a - 16'd1;
      end
      default: begin
        res_next = {8'd0, r8};
      end
    endcase
  end

  assign req.ready = !skid_valid;
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      flags      <= '0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        flags <= flags_next;
      end
      if (out_free) begin
        out_valid  <= skid_valid || accept;
        skid_valid <= 1'b0;
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_result <= skid_result;
        out_flags  <= skid_flags;
      end else if (accept) begin
        out_result <= res_next;
        out_flags  <= flags_next;
      end
    end else if (accept) begin
      skid_result <= res_next;
      skid_flags  <= flags_next;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.result    = out_result;
  assign rsp.flags_out = out_flags;

  `ASSERT_IMPLY(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `ASSERT_IMPLY(a_stall_only_when_full, clk, rst, !req.ready, rsp.valid && !$past(rsp.ready))
  `ASSERT_NEXT(a_set_keeps_flags, clk, rst, accept && req.mode == MODE_SET, flags == $past(flags))
  `ASSERT_NEXT(a_accept_gives_result, clk, rst, accept, out_valid)

endmodule
`default_nettype wire

### sim/alu_checker_pkg.sv
// Scoreboard for the flag ALU: a copy of the Z/N/H/C flag register and a queue of awaited results.
// Depends on lralu_pkg for the field types, the flag layout and the operation codes.
`timescale 1ns / 100ps
package alu_checker_pkg;
  import lralu_pkg::*;

  typedef struct {
    word_t  result;
    flags_t flags;
  } alu_outcome_t;

  class alu_checker;
    flags_t       flag_reg;
    alu_outcome_t awaited_results[$];
    word_t        last_result;
    int           mismatches;

    function new();
      flag_reg = '0;
      last_result = '0;
      mismatches = 0;
    endfunction

    function alu_outcome_t compute_op(mode_t m, word_t a16, word_t b16, bit_idx_t bi);
      byte_t        a;
      byte_t        b;
      byte_t        r;
      byte_t        adj;
      word_t        w;
      logic         wide;
      logic         t;
      logic [8:0]   s9;
      logic [4:0]   s5;
      logic [16:0]  s17;
      logic [12:0]  s13;
      flags_t       f;
      flags_t       nf;
      alu_outcome_t o;
      a = a16[7:0];
      b = b16[7:0];
      f = flag_reg;
      nf = f;
      r = 8'h00;
      w = 16'h0000;
      wide = 1'b0;
      t = 1'b0;
      case (m)
        MODE_ADD, MODE_ADC: begin
          t = (m == MODE_ADC) ? f.c : 1'b0;
          s9 = {1'b0, a} + {1'b0, b} + {8'h00, t};
          s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, t};
          r = s9[7:0];
          nf = {r == 8'h00, 1'b0, s5[4], s9[8]};
        end
        MODE_SUB, MODE_SBC, MODE_CP: begin
          t = (m == MODE_SBC) ? f.c : 1'b0;
          s9 = {1'b0, a} - {1'b0, b} - {8'h00, t};
          s5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, t};
          r = s9[7:0];
          nf = {r == 8'h00, 1'b1, s5[4], s9[8]};
          if (m == MODE_CP) r = a;
        end
        MODE_AND: begin
          r = a & b;
          nf = {r == 8'h00, 1'b0, 1'b1, 1'b0};
        end
        MODE_OR: begin
          r = a | b;
          nf = {r == 8'h00, 3'b000};
        end
        MODE_XOR: begin
          r = a ^ b;
          nf = {r == 8'h00, 3'b000};
        end
        MODE_INC: begin
          r = a + 8'h01;
          nf = {r == 8'h00, 1'b0, a[3:0] == 4'hF, f.c};
        end
        MODE_DEC: begin
          r = a - 8'h01;
          nf = {r == 8'h00, 1'b1, a[3:0] == 4'h0, f.c};
        end
        MODE_SWAP: begin
          r = {a[3:0], a[7:4]};
          nf = {r == 8'h00, 3'b000};
        end
        MODE_DAA: begin
          adj = 8'h00;
          nf = {1'b0, f.n, 1'b0, f.c};
          if (!f.n) begin
            if (a > DAA_BCD_MAX || f.c) begin
              adj = adj | DAA_ADJ_HI;
              nf.c = 1'b1;
            end
            if (a[3:0] > NIBBLE_MAX || f.h) adj = adj | DAA_ADJ_LO;
          end else begin
            if (f.c && !f.h) adj = adj | DAA_SUB_HI;
            if (f.h) adj = adj | DAA_SUB_LO | (f.c ? DAA_SUB_LO_CY : DAA_SUB_LO_NCY);
          end
          r = a + adj;
          nf.z = (r == 8'h00);
        end
        MODE_CPL: begin
          r = ~a;
          nf = {f.z, 1'b1, 1'b1, f.c};
        end
        MODE_CCF: begin
          r = a;
          nf = {f.z, 1'b0, 1'b0, ~f.c};
        end
        MODE_SCF: begin
          r = a;
          nf = {f.z, 1'b0, 1'b0, 1'b1};
        end
        MODE_RLCA: begin
          r = {a[6:0], a[7]};
          nf = {3'b000, a[7]};
        end
        MODE_RLA: begin
          r = {a[6:0], f.c};
          nf = {3'b000, a[7]};
        end
        MODE_RRCA: begin
          r = {a[0], a[7:1]};
          nf = {3'b000, a[0]};
        end
        MODE_RRA: begin
          r = {f.c, a[7:1]};
          nf = {3'b000, a[0]};
        end
        MODE_RLC: begin
          r = {a[6:0], a[7]};
          nf = {r == 8'h00, 2'b00, a[7]};
        end
        MODE_RL: begin
          r = {a[6:0], f.c};
          nf = {r == 8'h00, 2'b00, a[7]};
        end
        MODE_RRC: begin
          r = {a[0], a[7:1]};
          nf = {r == 8'h00, 2'b00, a[0]};
        end
        MODE_RR: begin
          r = {f.c, a[7:1]};
          nf = {r == 8'h00, 2'b00, a[0]};
        end
        MODE_SLA: begin
          r = {a[6:0], 1'b0};
          nf = {r == 8'h00, 2'b00, a[7]};
        end
        MODE_SRA: begin
          r = {a[7], a[7:1]};
          nf = {r == 8'h00, 2'b00, a[0]};
        end
        MODE_SRL: begin
          r = {1'b0, a[7:1]};
          nf = {r == 8'h00, 2'b00, a[0]};
        end
        MODE_BIT: begin
          r = a;
          nf = {~a[bi], 1'b0, 1'b1, f.c};
        end
        MODE_SET: r = a | (8'h01 << bi);
        MODE_RES: r = a & ~(8'h01 << bi);
        MODE_ADD16: begin
          wide = 1'b1;
          s17 = {1'b0, a16} + {1'b0, b16};
          s13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
          w = s17[15:0];
          nf = {f.z, 1'b0, s13[12], s17[16]};
        end
        MODE_ADDSP: begin
          wide = 1'b1;
          w = a16 + {{8{b[7]}}, b};
          s9 = {1'b0, a} + {1'b0, b};
          s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]};
          nf = {2'b00, s5[4], s9[8]};
        end
        MODE_INC16: begin
          wide = 1'b1;
          w = a16 + 16'h0001;
        end
        MODE_DEC16: begin
          wide = 1'b1;
          w = a16 - 16'h0001;
        end
        default: begin
          wide = 1'b1;
          w = 16'h0000;
        end
      endcase
      flag_reg = nf;
      o.result = wide ? w : {8'h00, r};
      o.flags = nf;
      return o;
    endfunction

    function void note_op(mode_t m, word_t a16, word_t b16, bit_idx_t bi);
      alu_outcome_t o;
      o = compute_op(m, a16, b16, bi);
      last_result = o.result;
      awaited_results.push_back(o);
    endfunction

    function void check_result(word_t res, logic [3:0] fl);
      alu_outcome_t e;
      if (awaited_results.size() == 0) begin
        $error("Result transfer with no operation outstanding: result %h, flags_out %h",
               res, fl);
        mismatches++;
        return;
      end
      e = awaited_results.pop_front();
      if (res !== e.result) begin
        $error("result: expected %h, actual %h", e.result, res);
        mismatches++;
      end
      if (fl !== e.flags) begin
        $error("flags_out: expected %b, actual %b", e.flags, fl);
        mismatches++;
      end
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction
  endclass
endpackage

### sim/tb_top.sv
// Top-level testbench for cpu_alu_with_flags_core: directed and random operations with random stalls.
// Depends on lralu_pkg, the lralu_if.sv interfaces and the scoreboard in alu_checker_pkg.
`timescale 1ns / 100ps
module tb_top;
  import lralu_pkg::*;
  import alu_checker_pkg::*;

  localparam mode_t MODE_FIRST_UNUSED = 6'd33;
  localparam mode_t MODE_LAST_CODE    = 6'd63;
  localparam int    RANDOM_OPS        = 1750;
  localparam int    STEADY_FROM       = 1600;
  localparam int    DRAIN_EVERY       = 600;

  logic clk;
  logic rst;
  logic steady;
  alu_checker sb = new();

  lralu_req_if req_ch();
  lralu_rsp_if rsp_ch();

  cpu_alu_with_flags_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        sb.note_op(req_ch.mode, req_ch.operand_a, req_ch.operand_b, req_ch.bit_index);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        sb.check_result(rsp_ch.result, rsp_ch.flags_out);
      end
    end
  end

  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return {8'h00, 8'($urandom)};
      3: return {8'hFF, 8'($urandom)};
      4: return {8'($urandom), 8'h80};
      5: return {8'($urandom), 8'h7F};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic word_t pick_bcd();
    return {8'($urandom), 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  task automatic send_op(mode_t m, word_t a, word_t b, bit_idx_t bi);
    req_ch.valid = 1'b1;
    req_ch.mode = m;
    req_ch.operand_a = a;
    req_ch.operand_b = b;
    req_ch.bit_index = bi;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic idle_sender(int cycles);
    req_ch.valid = 1'b0;
    repeat (cycles) begin
      req_ch.mode = mode_t'($urandom);
      req_ch.operand_a = word_t'($urandom);
      req_ch.operand_b = word_t'($urandom);
      req_ch.bit_index = bit_idx_t'($urandom);
      @(negedge clk);
    end
  endtask

  task automatic run_directed();
    send_op(MODE_ADD, 16'h00FF, 16'h0001, 3'd0);
    send_op(MODE_ADC, 16'h000F, 16'hFF00, 3'd0);
    send_op(MODE_SUB, 16'h0000, 16'h0001, 3'd0);
    send_op(MODE_SBC, 16'h0010, 16'h000F, 3'd0);
    send_op(MODE_CP, 16'hFF3C, 16'h003C, 3'd0);
    send_op(MODE_AND, 16'hFFF0, 16'h000F, 3'd0);
    send_op(MODE_OR, 16'h0000, 16'h0000, 3'd0);
    send_op(MODE_XOR, 16'hFFFF, 16'hFFFF, 3'd0);
    send_op(MODE_INC, 16'h00FF, 16'h0000, 3'd0);
    send_op(MODE_DEC, 16'h0000, 16'h0000, 3'd0);
    send_op(MODE_SWAP, 16'h00F0, 16'h0000, 3'd0);
    send_op(MODE_ADD, 16'h0045, 16'h0038, 3'd0);
    send_op(MODE_DAA, 16'h007D, 16'h0000, 3'd0);
    send_op(MODE_SUB, 16'h0042, 16'h0015, 3'd0);
    send_op(MODE_DAA, 16'h002D, 16'h0000, 3'd0);
    send_op(MODE_ADD, 16'h0099, 16'h0099, 3'd0);
    send_op(MODE_DAA, 16'h0032, 16'h0000, 3'd0);
    send_op(MODE_CPL, 16'h0055, 16'h0000, 3'd0);
    send_op(MODE_SCF, 16'h0000, 16'h0000, 3'd0);
    send_op(MODE_CCF, 16'h0000, 16'h0000, 3'd0);
    send_op(MODE_RLCA, 16'h0080, 16'h0000, 3'd0);
    send_op(MODE_RLA, 16'h0000, 16'h0000, 3'd0);
    send_op(MODE_RRCA, 16'h0001, 16'h0000, 3'd0);
    send_op(MODE_RRA, 16'h0000, 16'h0000, 3'd0);
    send_op(MODE_RLC, 16'h0000, 16'h0000, 3'd0);
    send_op(MODE_RL, 16'h0080, 16'h0000, 3'd0);
    send_op(MODE_RRC, 16'h0001, 16'h0000, 3'd0);
    send_op(MODE_RR, 16'h0001, 16'h0000, 3'd0);
    send_op(MODE_SLA, 16'h0080, 16'h0000, 3'd0);
    send_op(MODE_SRA, 16'h0080, 16'h0000, 3'd0);
    send_op(MODE_SRL, 16'h0001, 16'h0000, 3'd0);
    send_op(MODE_BIT, 16'h007F, 16'h0000, 3'd7);
    send_op(MODE_BIT, 16'h0001, 16'h0000, 3'd0);
    send_op(MODE_SET, 16'hFF00, 16'h0000, 3'd7);
    send_op(MODE_RES, 16'h00FF, 16'h0000, 3'd0);
    send_op(MODE_ADD16, 16'hFFFF, 16'h0001, 3'd0);
    send_op(MODE_ADD16, 16'h0FFF, 16'h0001, 3'd0);
    send_op(MODE_ADDSP, 16'h0000, 16'h00FF, 3'd0);
    send_op(MODE_ADDSP, 16'hFFFF, 16'h0001, 3'd0);
    send_op(MODE_INC16, 16'hFFFF, 16'h0000, 3'd0);
    send_op(MODE_DEC16, 16'h0000, 16'h0000, 3'd0);
    send_op(MODE_FIRST_UNUSED, 16'hFFFF, 16'hFFFF, 3'd7);
    send_op(MODE_LAST_CODE, 16'h1234, 16'h5678, 3'd3);
  endtask

  initial begin
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!steady && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  end

  initial begin
    mode_t bcd_ops [4];
    int    n_sent;
    int    next_drain;
    int    choice;
    bcd_ops = '{MODE_ADD, MODE_ADC, MODE_SUB, MODE_SBC};
    n_sent = 0;
    next_drain = DRAIN_EVERY;
    steady = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_ADD;
    req_ch.operand_a = '0;
    req_ch.operand_b = '0;
    req_ch.bit_index = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();

    while (n_sent < RANDOM_OPS) begin
      if (n_sent >= STEADY_FROM) steady = 1'b1;
      if (n_sent >= next_drain) begin
        req_ch.valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        next_drain += DRAIN_EVERY;
      end
      if (!steady && $urandom_range(0, 7) == 0) idle_sender($urandom_range(1, 19));
      choice = $urandom_range(0, 99);
      if (choice < 20) begin
        send_op(bcd_ops[$urandom_range(0, 3)], pick_bcd(), pick_bcd(),
                bit_idx_t'($urandom));
        send_op(MODE_DAA, sb.last_result, pick_word(), bit_idx_t'($urandom));
        n_sent += 2;
      end else if (choice < 23) begin
        send_op(mode_t'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST_CODE)), pick_word(),
                pick_word(), bit_idx_t'($urandom));
        n_sent++;
      end else begin
        send_op(mode_t'($urandom_range(MODE_ADD, MODE_DEC16)), pick_word(), pick_word(),
                bit_idx_t'($urandom));
        n_sent++;
      end
    end
    req_ch.valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end
endmodule
